// ----- rtl/dpec_pkg.sv -----
// Shared widths, constants and payload types of the disk pair collision block.
package dpec_pkg;

  localparam int POS_W   = 24;  // Q16.8 centre coordinate
  localparam int VEL_W   = 16;  // Q8.8 velocity
  localparam int RAD_W   = 16;  // Q8.8 radius
  localparam int DIFF_W  = POS_W + 1;           // full centre difference
  localparam int DS_W    = 18;                  // centre difference on a hit
  localparam int RS_W    = RAD_W + 1;           // radius sum
  localparam int RSQ_W   = 2 * RS_W;            // squared radius sum
  localparam int DSQ_W   = 2 * DIFF_W + 1;      // squared distance
  localparam int DOT_W   = VEL_W + DS_W + 1;    // v . d
  localparam int PROD_W  = DS_W + DOT_W;        // d * (v . d)
  localparam int NUM_W   = PROD_W;              // divider dividend
  localparam int DEN_W   = 35;                  // divider divisor
  localparam int Q_W     = 18;                  // quotient magnitude bits
  localparam int P_W     = Q_W + 1;             // signed quotient
  localparam int WT_W    = 18;                  // disk weight
  localparam int R2_W    = 2 * RAD_W;           // r*r
  localparam int PI_W    = 31;
  localparam int WPROD_W = R2_W + PI_W;         // r*r*pi
  localparam int WSHIFT  = 45;
  localparam int WP_W    = WT_W + 1 + P_W;      // weight times parallel part
  localparam int MEAN_W  = WP_W + 2;            // 2*(wa*pa + wb*pb)
  localparam int NV_W    = 22;                  // unsaturated new velocity

  localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [VEL_W-1:0] vel_a_x;
    logic signed [VEL_W-1:0] vel_a_y;
    logic        [RAD_W-1:0] radius_a;
    logic                    visible_a;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [VEL_W-1:0] vel_b_x;
    logic signed [VEL_W-1:0] vel_b_y;
    logic        [RAD_W-1:0] radius_b;
    logic                    visible_b;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic                    coincident;
    logic signed [VEL_W-1:0] new_vel_a_x;
    logic signed [VEL_W-1:0] new_vel_a_y;
    logic signed [VEL_W-1:0] new_vel_b_x;
    logic signed [VEL_W-1:0] new_vel_b_y;
  } out_t;

endpackage

// ----- rtl/dpec_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, signed result.
module dpec_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [dpec_pkg::NUM_W-1:0]           num_i,
  input  logic [dpec_pkg::DEN_W-1:0]           den_i,
  input  logic                                 neg_i,
  output logic signed [dpec_pkg::P_W-1:0]      q_o
);

  logic [dpec_pkg::NUM_W-1:0] rem_r [dpec_pkg::Q_W-1];
  logic [dpec_pkg::DEN_W-1:0] den_r [dpec_pkg::Q_W-1];
  logic [dpec_pkg::Q_W-1:0]   q_r   [dpec_pkg::Q_W];
  logic                       neg_r [dpec_pkg::Q_W];

  genvar k;
  generate
    for (k = 0; k < dpec_pkg::Q_W; k++) begin : g_stage
      localparam int SH = dpec_pkg::Q_W - 1 - k;
      logic [dpec_pkg::NUM_W-1:0] rem_in;
      logic [dpec_pkg::DEN_W-1:0] den_in;
      logic [dpec_pkg::Q_W-1:0]   q_in;
      logic                       neg_in;
      logic [dpec_pkg::NUM_W:0]   trial;
      logic                       ge;
      logic [dpec_pkg::Q_W-1:0]   q_nxt;

      if (k == 0) begin : g_first
        assign rem_in = num_i;
        assign den_in = den_i;
        assign q_in   = '0;
        assign neg_in = neg_i;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
        assign q_in   = q_r[k-1];
        assign neg_in = neg_r[k-1];
      end

      always_comb begin
        trial     = {{(dpec_pkg::NUM_W + 1 - dpec_pkg::DEN_W){1'b0}}, den_in} << SH;
        ge        = {1'b0, rem_in} >= trial;
        q_nxt     = q_in;
        q_nxt[SH] = ge;
      end

      if (k < dpec_pkg::Q_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k] <= ge ? (rem_in - trial[dpec_pkg::NUM_W-1:0]) : rem_in;
            den_r[k] <= den_in;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k]   <= q_nxt;
          neg_r[k] <= neg_in;
        end
      end
    end
  endgenerate

  // apply the sign to the rounded magnitude
  always_comb begin
    if (neg_r[dpec_pkg::Q_W-1]) begin
      q_o = -$signed({1'b0, q_r[dpec_pkg::Q_W-1]});
    end else begin
      q_o = $signed({1'b0, q_r[dpec_pkg::Q_W-1]});
    end
  end

endmodule

// ----- rtl/disk_pair_elastic_collision.sv -----
// Disk pair elastic collision: fully pipelined, one transfer per cycle in and out while unstalled.
//
// Each input transfer carries two disks; each output transfer gives the hit and
// coincident flags and the two new velocities, saturated to 16 bits. The pipe
// takes a new pair in every cycle unless stalled and returns results in order.
// The path is five arithmetic stages (difference, products, sums, projections,
// rounding setup), an 18-stage restoring divider for the four parallel parts,
// two stages for the weighted sum, a second 18-stage divider for the weighted
// mean, and the output register. Both dividers retire one quotient bit per
// stage, which sets the latency. out_stall freezes every stage together, so
// in_stall is high exactly while a finished result waits in the output
// register and is stalled. Pairs that miss, or whose centres coincide, return
// the input velocities unchanged.
module disk_pair_elastic_collision (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dpec_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dpec_pkg::out_t  out_data
);

  // velocities carried alongside the arithmetic
  typedef struct packed {
    logic signed [dpec_pkg::VEL_W-1:0] ax;
    logic signed [dpec_pkg::VEL_W-1:0] ay;
    logic signed [dpec_pkg::VEL_W-1:0] bx;
    logic signed [dpec_pkg::VEL_W-1:0] by;
  } vel_t;

  typedef struct packed {
    logic                      hit;
    logic                      coin;
    vel_t                      vel;
    logic [dpec_pkg::WT_W-1:0] wa;
    logic [dpec_pkg::WT_W-1:0] wb;
  } sb1_t;

  typedef struct packed {
    logic                             hit;
    logic                             coin;
    logic                             eq;
    vel_t                             vel;
    logic signed [dpec_pkg::P_W-1:0]  pax;
    logic signed [dpec_pkg::P_W-1:0]  pay;
    logic signed [dpec_pkg::P_W-1:0]  pbx;
    logic signed [dpec_pkg::P_W-1:0]  pby;
  } sb2_t;

  function automatic logic signed [dpec_pkg::VEL_W-1:0] sat16(
    input logic signed [dpec_pkg::NV_W-1:0] v
  );
    logic signed [dpec_pkg::VEL_W-1:0] r;
    if (v > $signed(dpec_pkg::NV_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed(dpec_pkg::NV_W'(32768))) begin
      r = -16'sh8000;
    end else begin
      r = v[dpec_pkg::VEL_W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  // advance the whole pipe unless a result is held by the receiver
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;

  // ---------------- stage 1: centre differences, radius sum
  logic                                  v1_r;
  logic signed [dpec_pkg::DIFF_W-1:0]    dx1_r, dy1_r;
  logic        [dpec_pkg::RS_W-1:0]      rs1_r;
  logic        [dpec_pkg::RAD_W-1:0]     ra1_r, rb1_r;
  logic                                  vis1_r;
  vel_t                                  vel1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= $signed({in_data.pos_b_x[dpec_pkg::POS_W-1], in_data.pos_b_x})
              - $signed({in_data.pos_a_x[dpec_pkg::POS_W-1], in_data.pos_a_x});
      dy1_r  <= $signed({in_data.pos_b_y[dpec_pkg::POS_W-1], in_data.pos_b_y})
              - $signed({in_data.pos_a_y[dpec_pkg::POS_W-1], in_data.pos_a_y});
      rs1_r  <= {1'b0, in_data.radius_a} + {1'b0, in_data.radius_b};
      ra1_r  <= in_data.radius_a;
      rb1_r  <= in_data.radius_b;
      vis1_r <= in_data.visible_a & in_data.visible_b;
      vel1_r <= '{ax: in_data.vel_a_x, ay: in_data.vel_a_y,
                  bx: in_data.vel_b_x, by: in_data.vel_b_y};
    end
  end

  // ---------------- stage 2: squares and dot product terms
  logic                                  v2_r;
  logic signed [2*dpec_pkg::DIFF_W-1:0]  dxx2_r, dyy2_r;
  logic        [dpec_pkg::RSQ_W-1:0]     rsq2_r;
  logic signed [dpec_pkg::DOT_W-2:0]     tax2_r, tay2_r, tbx2_r, tby2_r;
  logic signed [dpec_pkg::DS_W-1:0]      dxs2_r, dys2_r;
  logic        [dpec_pkg::R2_W-1:0]      r2a2_r, r2b2_r;
  logic                                  vis2_r;
  vel_t                                  vel2_r;
  logic signed [dpec_pkg::DS_W-1:0]      dxs1, dys1;

  // on a hit both differences fit in the short form
  assign dxs1 = dx1_r[dpec_pkg::DS_W-1:0];
  assign dys1 = dy1_r[dpec_pkg::DS_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dxx2_r <= dx1_r * dx1_r;
      dyy2_r <= dy1_r * dy1_r;
      rsq2_r <= rs1_r * rs1_r;
      tax2_r <= vel1_r.ax * dxs1;
      tay2_r <= vel1_r.ay * dys1;
      tbx2_r <= vel1_r.bx * dxs1;
      tby2_r <= vel1_r.by * dys1;
      dxs2_r <= dxs1;
      dys2_r <= dys1;
      r2a2_r <= ra1_r * ra1_r;
      r2b2_r <= rb1_r * rb1_r;
      vis2_r <= vis1_r;
      vel2_r <= vel1_r;
    end
  end

  // ---------------- stage 3: distance compare, dot sums, weight products
  logic                                  v3_r;
  logic                                  hit3_r, coin3_r;
  logic        [dpec_pkg::DEN_W-1:0]     den3_r;
  logic signed [dpec_pkg::DOT_W-1:0]     dota3_r, dotb3_r;
  logic        [dpec_pkg::WPROD_W-1:0]   wpa3_r, wpb3_r;
  logic signed [dpec_pkg::DS_W-1:0]      dxs3_r, dys3_r;
  vel_t                                  vel3_r;
  logic        [dpec_pkg::DSQ_W-1:0]     dsq2;
  logic                                  hit2;

  always_comb begin
    dsq2 = dpec_pkg::DSQ_W'($unsigned(dxx2_r)) + dpec_pkg::DSQ_W'($unsigned(dyy2_r));
    hit2 = vis2_r && (dsq2 <= dpec_pkg::DSQ_W'(rsq2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit3_r  <= hit2;
      coin3_r <= hit2 && (dsq2 == '0);
      den3_r  <= dsq2[dpec_pkg::DEN_W-1:0];
      dota3_r <= dpec_pkg::DOT_W'(tax2_r) + dpec_pkg::DOT_W'(tay2_r);
      dotb3_r <= dpec_pkg::DOT_W'(tbx2_r) + dpec_pkg::DOT_W'(tby2_r);
      wpa3_r  <= dpec_pkg::WPROD_W'(r2a2_r) * dpec_pkg::WPROD_W'(dpec_pkg::PI_Q29);
      wpb3_r  <= dpec_pkg::WPROD_W'(r2b2_r) * dpec_pkg::WPROD_W'(dpec_pkg::PI_Q29);
      dxs3_r  <= dxs2_r;
      dys3_r  <= dys2_r;
      vel3_r  <= vel2_r;
    end
  end

  // ---------------- stage 4: projection numerators, weights
  logic                                  v4_r;
  logic                                  hit4_r, coin4_r;
  logic        [dpec_pkg::DEN_W-1:0]     den4_r;
  logic signed [dpec_pkg::PROD_W-1:0]    nax4_r, nay4_r, nbx4_r, nby4_r;
  logic        [dpec_pkg::WT_W-1:0]      wa4_r, wb4_r;
  vel_t                                  vel4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r  <= hit3_r;
      coin4_r <= coin3_r;
      den4_r  <= den3_r;
      nax4_r  <= dxs3_r * dota3_r;
      nay4_r  <= dys3_r * dota3_r;
      nbx4_r  <= dxs3_r * dotb3_r;
      nby4_r  <= dys3_r * dotb3_r;
      wa4_r   <= wpa3_r[dpec_pkg::WSHIFT +: dpec_pkg::WT_W];
      wb4_r   <= wpb3_r[dpec_pkg::WSHIFT +: dpec_pkg::WT_W];
      vel4_r  <= vel3_r;
    end
  end

  // ---------------- stage 5: magnitudes plus half divisor for rounding
  logic                                  v5_r;
  logic        [dpec_pkg::NUM_W-1:0]     num5_r [4];
  logic                                  neg5_r [4];
  logic        [dpec_pkg::DEN_W-1:0]     den5_r;
  sb1_t                                  sb5_r;
  logic signed [dpec_pkg::PROD_W-1:0]    pn4 [4];

  assign pn4[0] = nax4_r;
  assign pn4[1] = nay4_r;
  assign pn4[2] = nbx4_r;
  assign pn4[3] = nby4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg5_r[i] <= pn4[i][dpec_pkg::PROD_W-1];
        num5_r[i] <= (pn4[i][dpec_pkg::PROD_W-1] ? $unsigned(-pn4[i]) : $unsigned(pn4[i]))
                   + dpec_pkg::NUM_W'(den4_r >> 1);
      end
      den5_r <= den4_r;
      sb5_r  <= '{hit: hit4_r, coin: coin4_r, vel: vel4_r, wa: wa4_r, wb: wb4_r};
    end
  end

  // ---------------- divider 1: parallel parts
  logic signed [dpec_pkg::P_W-1:0] p_d1 [4];
  sb1_t                            sb1_r [dpec_pkg::Q_W];
  logic                            v_d1_r [dpec_pkg::Q_W];

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_div1
      dpec_div u_div (
        .clk   (clk),
        .en    (en),
        .num_i (num5_r[g]),
        .den_i (den5_r),
        .neg_i (neg5_r[g]),
        .q_o   (p_d1[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= sb5_r;
      for (int i = 1; i < dpec_pkg::Q_W; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // ---------------- stage 6: weight the parallel parts
  logic                                  v6_r;
  sb2_t                                  sb6_r;
  logic        [dpec_pkg::WT_W:0]        wsum6_r;
  logic signed [dpec_pkg::WP_W-1:0]      max6_r, mbx6_r, may6_r, mby6_r;
  sb1_t                                  sb1_end;

  assign sb1_end = sb1_r[dpec_pkg::Q_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sb6_r   <= '{hit: sb1_end.hit, coin: sb1_end.coin, eq: sb1_end.wa == sb1_end.wb,
                   vel: sb1_end.vel, pax: p_d1[0], pay: p_d1[1], pbx: p_d1[2],
                   pby: p_d1[3]};
      wsum6_r <= {1'b0, sb1_end.wa} + {1'b0, sb1_end.wb};
      max6_r  <= $signed({1'b0, sb1_end.wa}) * p_d1[0];
      may6_r  <= $signed({1'b0, sb1_end.wa}) * p_d1[1];
      mbx6_r  <= $signed({1'b0, sb1_end.wb}) * p_d1[2];
      mby6_r  <= $signed({1'b0, sb1_end.wb}) * p_d1[3];
    end
  end

  // ---------------- stage 7: doubled weighted sums, rounding setup
  logic                                  v7_r;
  sb2_t                                  sb7_r;
  logic        [dpec_pkg::NUM_W-1:0]     num7_r [2];
  logic                                  neg7_r [2];
  logic        [dpec_pkg::DEN_W-1:0]     den7_r;
  logic signed [dpec_pkg::MEAN_W-1:0]    ms6 [2];

  always_comb begin
    ms6[0] = (dpec_pkg::MEAN_W'(max6_r) + dpec_pkg::MEAN_W'(mbx6_r)) <<< 1;
    ms6[1] = (dpec_pkg::MEAN_W'(may6_r) + dpec_pkg::MEAN_W'(mby6_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        neg7_r[i] <= ms6[i][dpec_pkg::MEAN_W-1];
        num7_r[i] <= dpec_pkg::NUM_W'(ms6[i][dpec_pkg::MEAN_W-1] ? $unsigned(-ms6[i])
                                                                 : $unsigned(ms6[i]))
                   + dpec_pkg::NUM_W'(wsum6_r >> 1);
      end
      den7_r <= dpec_pkg::DEN_W'(wsum6_r);
      sb7_r  <= sb6_r;
    end
  end

  // ---------------- divider 2: weighted mean
  logic signed [dpec_pkg::P_W-1:0] m_d2 [2];
  sb2_t                            sb2_r [dpec_pkg::Q_W];
  logic                            v_d2_r [dpec_pkg::Q_W];

  generate
    for (g = 0; g < 2; g++) begin : g_div2
      dpec_div u_div (
        .clk   (clk),
        .en    (en),
        .num_i (num7_r[g]),
        .den_i (den7_r),
        .neg_i (neg7_r[g]),
        .q_o   (m_d2[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= sb7_r;
      for (int i = 1; i < dpec_pkg::Q_W; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // ---------------- output: new velocities, saturation, selection
  sb2_t                              sb2_end;
  logic signed [dpec_pkg::NV_W-1:0]  vax, vay, vbx, vby;
  logic signed [dpec_pkg::NV_W-1:0]  pax, pay, pbx, pby, mx, my;
  logic signed [dpec_pkg::NV_W-1:0]  nax, nay, nbx, nby;
  dpec_pkg::out_t                    res;
  dpec_pkg::out_t                    out_data_r;

  assign sb2_end = sb2_r[dpec_pkg::Q_W-1];

  always_comb begin
    vax = dpec_pkg::NV_W'(sb2_end.vel.ax);
    vay = dpec_pkg::NV_W'(sb2_end.vel.ay);
    vbx = dpec_pkg::NV_W'(sb2_end.vel.bx);
    vby = dpec_pkg::NV_W'(sb2_end.vel.by);
    pax = dpec_pkg::NV_W'(sb2_end.pax);
    pay = dpec_pkg::NV_W'(sb2_end.pay);
    pbx = dpec_pkg::NV_W'(sb2_end.pbx);
    pby = dpec_pkg::NV_W'(sb2_end.pby);
    mx  = dpec_pkg::NV_W'(m_d2[0]);
    my  = dpec_pkg::NV_W'(m_d2[1]);
    if (sb2_end.eq) begin
      // equal weights: swap the parallel parts
      nax = vax - pax + pbx;
      nay = vay - pay + pby;
      nbx = vbx - pbx + pax;
      nby = vby - pby + pay;
    end else begin
      nax = vax - (pax <<< 1) + mx;
      nay = vay - (pay <<< 1) + my;
      nbx = vbx - (pbx <<< 1) + mx;
      nby = vby - (pby <<< 1) + my;
    end
    res.hit        = sb2_end.hit;
    res.coincident = sb2_end.coin;
    if (sb2_end.hit && !sb2_end.coin) begin
      res.new_vel_a_x = sat16(nax);
      res.new_vel_a_y = sat16(nay);
      res.new_vel_b_x = sat16(nbx);
      res.new_vel_b_y = sat16(nby);
    end else begin
      // miss or equal centres: hold the input velocities
      res.new_vel_a_x = sb2_end.vel.ax;
      res.new_vel_a_y = sb2_end.vel.ay;
      res.new_vel_b_x = sb2_end.vel.bx;
      res.new_vel_b_y = sb2_end.vel.by;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

  assign out_data = out_data_r;

  // ---------------- valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < dpec_pkg::Q_W; i++) begin
        v_d1_r[i] <= 1'b0;
        v_d2_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v_d1_r[0] <= v5_r;
      for (int i = 1; i < dpec_pkg::Q_W; i++) begin
        v_d1_r[i] <= v_d1_r[i-1];
        v_d2_r[i] <= v_d2_r[i-1];
      end
      v6_r        <= v_d1_r[dpec_pkg::Q_W-1];
      v7_r        <= v6_r;
      v_d2_r[0]   <= v7_r;
      out_valid_r <= v_d2_r[dpec_pkg::Q_W-1];
    end
  end

endmodule
